// ----- hdl/hrp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrp_pkg: shared types and constants for the hue rotation pixel block
// Pixel beat types, sideband structs carried down the pipeline, sector
// codes, register map and width helpers used by every module.
// ----------------------------------------------------------------------------
package hrp_pkg;

  // pixel and register widths
  localparam int PIX_W          = 8;
  localparam int PIX_MAX        = (2 ** PIX_W) - 1;
  localparam int HUE_FRAC_DEF   = 6;
  localparam int OFFSET_W       = 9;
  localparam int OFFSET_MAX     = (2 ** OFFSET_W) - 1;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 9'd180;

  // hue geometry in whole degrees
  localparam int DEG_PER_SECTOR = 60;
  localparam int SECTORS        = 6;

  // register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_HUE_OFFSET = '0;

  // input and result beats
  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
  } pix_out_t;

  // hue base picked by the minimum channel
  typedef enum logic [1:0] {
    HUE_BASE_0,
    HUE_BASE_120,
    HUE_BASE_240
  } hue_base_t;

  // 60 degree sectors of the rotated hue
  typedef enum logic [2:0] {
    SEC_R_Y,
    SEC_Y_G,
    SEC_G_C,
    SEC_C_B,
    SEC_B_M,
    SEC_M_R
  } sector_t;

  // sideband riding along the hue divider
  typedef struct packed {
    logic [PIX_W-1:0] min_val;
    logic [PIX_W-1:0] chroma;
    hue_base_t        base;
  } hue_side_t;

  // sideband for the pixel rebuild
  typedef struct packed {
    logic [PIX_W-1:0] min_val;
    logic [PIX_W-1:0] chroma;
    sector_t          sector;
  } x_side_t;

  // 60 degrees in hue units
  function automatic int sixty_of(input int frac);
    return DEG_PER_SECTOR << frac;
  endfunction

  // rotated hue before the modulo
  function automatic int hue_w_of(input int frac);
    return $clog2(SECTORS * sixty_of(frac) + (OFFSET_MAX << frac));
  endfunction

  // numerator of the hue division
  function automatic int num1_w_of(input int frac);
    return $clog2(2 * sixty_of(frac) * PIX_MAX + 1);
  endfunction

  // hue quotient, up to 120 degrees
  function automatic int quo1_w_of(input int frac);
    return $clog2(2 * sixty_of(frac) + 1);
  endfunction

  // sector weight, 0 to 60 degrees
  function automatic int m_w_of(input int frac);
    return $clog2(sixty_of(frac) + 1);
  endfunction

endpackage

// ----- hdl/hrp_div_cell.sv -----
// ----------------------------------------------------------------------------
// hrp_div_cell: one quotient bit of a pipelined restoring divider
// Compares the running remainder with the divisor shifted to this cell's bit,
// subtracts when it fits and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module hrp_div_cell #(
  parameter int NUM_W   = 8,
  parameter int DEN_W   = 8,
  parameter int QUO_W   = 8,
  parameter int SIDE_W  = 1,
  parameter int BIT_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              prv_valid,
  input  logic [NUM_W-1:0]  prv_rem,
  input  logic [DEN_W-1:0]  prv_den,
  input  logic [QUO_W-1:0]  prv_quo,
  input  logic [SIDE_W-1:0] prv_side,
  output logic              prv_free,
  output logic              nxt_valid,
  output logic [NUM_W-1:0]  nxt_rem,
  output logic [DEN_W-1:0]  nxt_den,
  output logic [QUO_W-1:0]  nxt_quo,
  output logic [SIDE_W-1:0] nxt_side,
  input  logic              nxt_free
);
  import hrp_pkg::*;

  localparam int CMP_W = NUM_W + DEN_W;

  logic              valid_r;
  logic [NUM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r;
  logic [SIDE_W-1:0] side_r;
  logic [NUM_W-1:0]  rem_nxt;
  logic [QUO_W-1:0]  quo_nxt;
  logic [CMP_W-1:0]  step_w;
  logic [CMP_W-1:0]  rem_w;
  logic              load_w;

  // slot opens when empty or when the next cell takes our beat
  assign load_w   = !valid_r || nxt_free;
  assign prv_free = load_w;

  // trial subtract for this quotient bit
  always_comb begin
    step_w  = CMP_W'(prv_den) << BIT_IDX;
    rem_w   = CMP_W'(prv_rem);
    rem_nxt = prv_rem;
    quo_nxt = prv_quo;
    if (rem_w >= step_w) begin
      rem_nxt          = NUM_W'(rem_w - step_w);
      quo_nxt[BIT_IDX] = 1'b1;
    end
  end

  // beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_w) begin
      valid_r <= prv_valid;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (load_w) begin
      rem_r  <= rem_nxt;
      den_r  <= prv_den;
      quo_r  <= quo_nxt;
      side_r <= prv_side;
    end
  end

  assign nxt_valid = valid_r;
  assign nxt_rem   = rem_r;
  assign nxt_den   = den_r;
  assign nxt_quo   = quo_r;
  assign nxt_side  = side_r;

`ifndef SYNTHESIS
  // remainder must be below the divisor at this bit once the bit is settled
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (CMP_W'(rem_r) < (CMP_W'(den_r) << BIT_IDX)))
    else $error("divider cell remainder out of range");
`endif

endmodule

// ----- hdl/hrp_div_chain.sv -----
// ----------------------------------------------------------------------------
// hrp_div_chain: row of divider cells, one per quotient bit
// Numerator enters as the first remainder; the quotient builds up MSB first
// while the sideband travels with its beat.
// ----------------------------------------------------------------------------
module hrp_div_chain #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              prv_valid,
  input  logic [NUM_W-1:0]  prv_num,
  input  logic [DEN_W-1:0]  prv_den,
  input  logic [SIDE_W-1:0] prv_side,
  output logic              prv_free,
  output logic              nxt_valid,
  output logic [QUO_W-1:0]  nxt_quo,
  output logic [SIDE_W-1:0] nxt_side,
  input  logic              nxt_free
);
  import hrp_pkg::*;

  logic              valid_c [QUO_W+1];
  logic              free_c  [QUO_W+1];
  logic [NUM_W-1:0]  rem_c   [QUO_W+1];
  logic [DEN_W-1:0]  den_c   [QUO_W+1];
  logic [QUO_W-1:0]  quo_c   [QUO_W+1];
  logic [SIDE_W-1:0] side_c  [QUO_W+1];

  // head of the row
  assign valid_c[0] = prv_valid;
  assign rem_c[0]   = prv_num;
  assign den_c[0]   = prv_den;
  assign quo_c[0]   = '0;
  assign side_c[0]  = prv_side;
  assign prv_free   = free_c[0];

  // one cell per quotient bit, most significant first
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    hrp_div_cell #(
      .NUM_W   (NUM_W),
      .DEN_W   (DEN_W),
      .QUO_W   (QUO_W),
      .SIDE_W  (SIDE_W),
      .BIT_IDX (QUO_W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .prv_valid (valid_c[k]),
      .prv_rem   (rem_c[k]),
      .prv_den   (den_c[k]),
      .prv_quo   (quo_c[k]),
      .prv_side  (side_c[k]),
      .prv_free  (free_c[k]),
      .nxt_valid (valid_c[k+1]),
      .nxt_rem   (rem_c[k+1]),
      .nxt_den   (den_c[k+1]),
      .nxt_quo   (quo_c[k+1]),
      .nxt_side  (side_c[k+1]),
      .nxt_free  (free_c[k+1])
    );
  end

  // tail of the row
  assign free_c[QUO_W] = nxt_free;
  assign nxt_valid     = valid_c[QUO_W];
  assign nxt_quo       = quo_c[QUO_W];
  assign nxt_side      = side_c[QUO_W];

endmodule

// ----- hdl/hrp_front.sv -----
// ----------------------------------------------------------------------------
// hrp_front: max, min, chroma and hue numerator
// First stage picks the hue base from the minimum channel; second stage scales
// the numerator by 60 degrees in hue units for the divider.
// ----------------------------------------------------------------------------
module hrp_front #(
  parameter int HUE_FRAC_BITS = hrp_pkg::HUE_FRAC_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          prv_valid,
  input  hrp_pkg::pix_in_t                              prv_pix,
  output logic                                          prv_free,
  output logic                                          nxt_valid,
  output logic [hrp_pkg::num1_w_of(HUE_FRAC_BITS)-1:0]  nxt_num,
  output logic [hrp_pkg::PIX_W-1:0]                     nxt_den,
  output hrp_pkg::hue_side_t                            nxt_side,
  input  logic                                          nxt_free
);
  import hrp_pkg::*;

  localparam int NUM_W = num1_w_of(HUE_FRAC_BITS);
  localparam logic [NUM_W-1:0] SIXTY_N = NUM_W'(sixty_of(HUE_FRAC_BITS));

  logic             a_valid_r;
  logic [PIX_W:0]   a_num_r;
  logic [PIX_W-1:0] a_den_r;
  hue_side_t        a_side_r;
  logic [PIX_W:0]   a_num_nxt;
  logic [PIX_W-1:0] a_den_nxt;
  hue_side_t        a_side_nxt;

  logic             b_valid_r;
  logic [NUM_W-1:0] b_num_r;
  logic [PIX_W-1:0] b_den_r;
  hue_side_t        b_side_r;

  logic             a_load_w;
  logic             b_load_w;
  logic [PIX_W-1:0] mx_w;
  logic [PIX_W-1:0] mn_w;
  logic [PIX_W-1:0] c_w;
  logic [PIX_W:0]   r_w;
  logic [PIX_W:0]   g_w;
  logic [PIX_W:0]   b_w;

  // stage handshake
  assign b_load_w = !b_valid_r || nxt_free;
  assign a_load_w = !a_valid_r || b_load_w;
  assign prv_free = a_load_w;

  // extremes, chroma and the sector's numerator
  always_comb begin
    r_w  = {1'b0, prv_pix.red_in};
    g_w  = {1'b0, prv_pix.green_in};
    b_w  = {1'b0, prv_pix.blue_in};
    mx_w = prv_pix.red_in;
    mn_w = prv_pix.red_in;
    if (prv_pix.green_in > mx_w) mx_w = prv_pix.green_in;
    if (prv_pix.blue_in > mx_w)  mx_w = prv_pix.blue_in;
    if (prv_pix.green_in < mn_w) mn_w = prv_pix.green_in;
    if (prv_pix.blue_in < mn_w)  mn_w = prv_pix.blue_in;
    c_w = mx_w - mn_w;

    a_side_nxt.min_val = mn_w;
    a_side_nxt.chroma  = c_w;
    a_den_nxt          = c_w;
    if (c_w == '0) begin
      // gray pixel: zero over one gives hue zero
      a_num_nxt       = '0;
      a_den_nxt       = PIX_W'(1);
      a_side_nxt.base = HUE_BASE_0;
    end else if (mn_w == prv_pix.blue_in) begin
      a_num_nxt       = g_w + {1'b0, c_w} - r_w;
      a_side_nxt.base = HUE_BASE_0;
    end else if (mn_w == prv_pix.red_in) begin
      a_num_nxt       = b_w + {1'b0, c_w} - g_w;
      a_side_nxt.base = HUE_BASE_120;
    end else begin
      a_num_nxt       = r_w + {1'b0, c_w} - b_w;
      a_side_nxt.base = HUE_BASE_240;
    end
  end

  // stage a valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_load_w) begin
      a_valid_r <= prv_valid;
    end
  end

  // stage a payload
  always_ff @(posedge clk) begin
    if (a_load_w) begin
      a_num_r  <= a_num_nxt;
      a_den_r  <= a_den_nxt;
      a_side_r <= a_side_nxt;
    end
  end

  // stage b valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_load_w) begin
      b_valid_r <= a_valid_r;
    end
  end

  // stage b payload: scale by 60 degrees
  always_ff @(posedge clk) begin
    if (b_load_w) begin
      b_num_r  <= SIXTY_N * NUM_W'(a_num_r);
      b_den_r  <= a_den_r;
      b_side_r <= a_side_r;
    end
  end

  assign nxt_valid = b_valid_r;
  assign nxt_num   = b_num_r;
  assign nxt_den   = b_den_r;
  assign nxt_side  = b_side_r;

endmodule

// ----- hdl/hrp_rotate.sv -----
// ----------------------------------------------------------------------------
// hrp_rotate: hue offset, sector and x numerator
// Adds the base and the offset and wraps at 360 degrees, finds the sector and
// its weight, then multiplies the weight by chroma for the x term.
// ----------------------------------------------------------------------------
module hrp_rotate #(
  parameter int HUE_FRAC_BITS = hrp_pkg::HUE_FRAC_DEF
) (
  input  logic                                                          clk,
  input  logic                                                          rst_n,
  input  logic                                                          prv_valid,
  input  logic [hrp_pkg::quo1_w_of(HUE_FRAC_BITS)-1:0]                  prv_quo,
  input  hrp_pkg::hue_side_t                                            prv_side,
  input  logic [hrp_pkg::OFFSET_W-1:0]                                  hue_offset,
  output logic                                                          prv_free,
  output logic                                                          nxt_valid,
  output logic [hrp_pkg::PIX_W+hrp_pkg::m_w_of(HUE_FRAC_BITS)-1:0]      nxt_num,
  output hrp_pkg::x_side_t                                              nxt_side,
  input  logic                                                          nxt_free
);
  import hrp_pkg::*;

  localparam int SIXTY = sixty_of(HUE_FRAC_BITS);
  localparam int HUE_W = hue_w_of(HUE_FRAC_BITS);
  localparam int M_W   = m_w_of(HUE_FRAC_BITS);
  localparam int N2_W  = PIX_W + M_W;

  localparam logic [HUE_W-1:0] S1_H     = HUE_W'(SIXTY);
  localparam logic [HUE_W-1:0] S2_H     = HUE_W'(2 * SIXTY);
  localparam logic [HUE_W-1:0] S3_H     = HUE_W'(3 * SIXTY);
  localparam logic [HUE_W-1:0] S4_H     = HUE_W'(4 * SIXTY);
  localparam logic [HUE_W-1:0] S5_H     = HUE_W'(5 * SIXTY);
  localparam logic [HUE_W-1:0] TURN_H   = HUE_W'(SECTORS * SIXTY);
  localparam logic [HUE_W-1:0] TURN2_H  = HUE_W'(2 * SECTORS * SIXTY);
  localparam logic [M_W-1:0]   SIXTY_M  = M_W'(SIXTY);

  // stage h: wrapped hue
  logic             h_valid_r;
  logic [HUE_W-1:0] hm_r;
  logic [PIX_W-1:0] h_mn_r;
  logic [PIX_W-1:0] h_c_r;
  logic [HUE_W-1:0] hm_nxt;

  // stage s: sector and weight
  logic             s_valid_r;
  logic [M_W-1:0]   s_m_r;
  x_side_t          s_side_r;
  logic [M_W-1:0]   s_m_nxt;
  sector_t          sec_nxt;

  // stage p: chroma times weight
  logic             p_valid_r;
  logic [N2_W-1:0]  p_num_r;
  x_side_t          p_side_r;

  logic             h_load_w;
  logic             s_load_w;
  logic             p_load_w;
  logic [HUE_W-1:0] base_w;
  logic [HUE_W-1:0] sum_w;
  logic [HUE_W-1:0] t_w;
  logic [HUE_W-1:0] d_w;

  // stage handshake
  assign p_load_w = !p_valid_r || nxt_free;
  assign s_load_w = !s_valid_r || p_load_w;
  assign h_load_w = !h_valid_r || s_load_w;
  assign prv_free = h_load_w;

  // base plus quotient plus offset, wrapped into one turn
  always_comb begin
    unique case (prv_side.base)
      HUE_BASE_120: base_w = S2_H;
      HUE_BASE_240: base_w = S4_H;
      default:      base_w = '0;
    endcase
    sum_w = base_w + HUE_W'(prv_quo) + (HUE_W'(hue_offset) << HUE_FRAC_BITS);
    if (sum_w >= TURN2_H) begin
      hm_nxt = sum_w - TURN2_H;
    end else if (sum_w >= TURN_H) begin
      hm_nxt = sum_w - TURN_H;
    end else begin
      hm_nxt = sum_w;
    end
  end

  // sector, position within the 120 degree pair, weight
  always_comb begin
    if (hm_r >= S5_H) begin
      sec_nxt = SEC_M_R;
      t_w     = hm_r - S4_H;
    end else if (hm_r >= S4_H) begin
      sec_nxt = SEC_B_M;
      t_w     = hm_r - S4_H;
    end else if (hm_r >= S3_H) begin
      sec_nxt = SEC_C_B;
      t_w     = hm_r - S2_H;
    end else if (hm_r >= S2_H) begin
      sec_nxt = SEC_G_C;
      t_w     = hm_r - S2_H;
    end else if (hm_r >= S1_H) begin
      sec_nxt = SEC_Y_G;
      t_w     = hm_r;
    end else begin
      sec_nxt = SEC_R_Y;
      t_w     = hm_r;
    end
    d_w     = (t_w >= S1_H) ? (t_w - S1_H) : (S1_H - t_w);
    s_m_nxt = SIXTY_M - M_W'(d_w);
  end

  // stage h registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
    end else if (h_load_w) begin
      h_valid_r <= prv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (h_load_w) begin
      hm_r   <= hm_nxt;
      h_mn_r <= prv_side.min_val;
      h_c_r  <= prv_side.chroma;
    end
  end

  // stage s registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (s_load_w) begin
      s_valid_r <= h_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_load_w) begin
      s_m_r            <= s_m_nxt;
      s_side_r.min_val <= h_mn_r;
      s_side_r.chroma  <= h_c_r;
      s_side_r.sector  <= sec_nxt;
    end
  end

  // stage p registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_load_w) begin
      p_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load_w) begin
      p_num_r  <= N2_W'(s_side_r.chroma) * N2_W'(s_m_r);
      p_side_r <= s_side_r;
    end
  end

  assign nxt_valid = p_valid_r;
  assign nxt_num   = p_num_r;
  assign nxt_side  = p_side_r;

`ifndef SYNTHESIS
  // wrapped hue stays inside one turn
  a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    h_valid_r |-> (hm_r < TURN_H))
    else $error("wrapped hue not below one turn");

  // sector weight never exceeds 60 degrees
  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |-> (s_m_r <= SIXTY_M))
    else $error("sector weight above 60 degrees");
`endif

endmodule

// ----- hdl/hue_rotation_pixel.sv -----
// ----------------------------------------------------------------------------
// hue_rotation_pixel: rotates the hue of an 8-bit RGB pixel stream
// Takes one pixel per clock and returns one pixel per clock while the output
// is not stalled. Each result passes two front stages, one divider cell per bit
// of the hue quotient, three rotate stages and the output register, where the
// x term is found by a reciprocal multiply. The row of divider cells sets most
// of the latency; throughput is set by the per-stage handshake, so a stalled
// output lets new pixels fill any empty stages behind it. The hue offset in
// degrees lives at byte address 0 of the APB port and resets to 180; the user
// must write it only while the stream is idle, which the block itself does not
// enforce. There is no start-up sweep; pixels are taken right after reset.
// ----------------------------------------------------------------------------
module hue_rotation_pixel #(
  parameter int HUE_FRAC_BITS = hrp_pkg::HUE_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input
  input  logic                            in_valid,
  input  hrp_pkg::pix_in_t                in_data,
  output logic                            in_stall,
  // pixel output
  output logic                            out_valid,
  output hrp_pkg::pix_out_t               out_data,
  input  logic                            out_stall,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hrp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hrp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hrp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import hrp_pkg::*;

  localparam int NUM1_W = num1_w_of(HUE_FRAC_BITS);
  localparam int QUO1_W = quo1_w_of(HUE_FRAC_BITS);
  localparam int M_W    = m_w_of(HUE_FRAC_BITS);
  localparam int NUM2_W = PIX_W + M_W;
  localparam int SIDE1_W = $bits(hue_side_t);

  // x = chroma * weight / (60 << frac): drop 4 << frac, then divide by 15
  // as a multiply by ceil(2^16 / 15), exact for values below 4681
  localparam int XN_W          = PIX_W + 4;
  localparam int XK_W          = 13;
  localparam int XP_W          = XN_W + XK_W;
  localparam int X_SHIFT       = HUE_FRAC_BITS + 2;
  localparam int X_RECIP_SHIFT = 16;
  localparam logic [XK_W-1:0] X_RECIP = XK_W'(4370);

  // configuration
  logic [OFFSET_W-1:0] hue_offset_r;
  logic                wr_en_w;
  logic                sel_offset_w;

  // front to hue divider
  logic                f_valid;
  logic [NUM1_W-1:0]   f_num;
  logic [PIX_W-1:0]    f_den;
  hue_side_t           f_side;
  logic                f_free;
  logic                front_free;

  // hue divider to rotate
  logic                q_valid;
  logic [QUO1_W-1:0]   q_quo;
  logic [SIDE1_W-1:0]  q_side;
  logic                q_free;

  // rotate to output
  logic                r_valid;
  logic [NUM2_W-1:0]   r_num;
  x_side_t             r_side;
  logic                r_free;

  // x term
  logic [XN_W-1:0]     x_n_w;
  logic [XP_W-1:0]     x_p_w;
  logic [PIX_W-1:0]    x_quo;

  // output register
  logic                out_valid_r;
  pix_out_t            out_data_r;
  pix_out_t            out_data_nxt;

  // register decode
  assign sel_offset_w = (paddr[CFG_ADDR_W-1:2] == REG_HUE_OFFSET);
  assign wr_en_w      = psel && penable && pwrite && sel_offset_w;
  assign pready       = 1'b1;
  assign prdata       = sel_offset_w ? CFG_DATA_W'(hue_offset_r) : '0;

  // hue offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_offset_r <= OFFSET_RESET;
    end else if (wr_en_w) begin
      hue_offset_r <= pwdata[OFFSET_W-1:0];
    end
  end

  // extremes and hue numerator
  hrp_front #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .prv_valid (in_valid),
    .prv_pix   (in_data),
    .prv_free  (front_free),
    .nxt_valid (f_valid),
    .nxt_num   (f_num),
    .nxt_den   (f_den),
    .nxt_side  (f_side),
    .nxt_free  (f_free)
  );

  assign in_stall = !front_free;

  // hue divider row
  hrp_div_chain #(
    .NUM_W  (NUM1_W),
    .DEN_W  (PIX_W),
    .QUO_W  (QUO1_W),
    .SIDE_W (SIDE1_W)
  ) u_hue_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .prv_valid (f_valid),
    .prv_num   (f_num),
    .prv_den   (f_den),
    .prv_side  (f_side),
    .prv_free  (f_free),
    .nxt_valid (q_valid),
    .nxt_quo   (q_quo),
    .nxt_side  (q_side),
    .nxt_free  (q_free)
  );

  // offset, wrap, sector and x numerator
  hrp_rotate #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_rotate (
    .clk        (clk),
    .rst_n      (rst_n),
    .prv_valid  (q_valid),
    .prv_quo    (q_quo),
    .prv_side   (hue_side_t'(q_side)),
    .hue_offset (hue_offset_r),
    .prv_free   (q_free),
    .nxt_valid  (r_valid),
    .nxt_num    (r_num),
    .nxt_side   (r_side),
    .nxt_free   (r_free)
  );

  // x term, divided by 60 degrees through the reciprocal
  assign x_n_w = XN_W'(r_num >> X_SHIFT);
  assign x_p_w = XP_W'(x_n_w) * XP_W'(X_RECIP);
  assign x_quo = x_p_w[X_RECIP_SHIFT +: PIX_W];

  // rebuild the pixel from min, chroma and x
  always_comb begin
    out_data_nxt.red_out   = r_side.min_val;
    out_data_nxt.green_out = r_side.min_val;
    out_data_nxt.blue_out  = r_side.min_val;
    case (r_side.sector)
      SEC_R_Y: begin
        out_data_nxt.red_out   = r_side.min_val + r_side.chroma;
        out_data_nxt.green_out = r_side.min_val + x_quo;
      end
      SEC_Y_G: begin
        out_data_nxt.red_out   = r_side.min_val + x_quo;
        out_data_nxt.green_out = r_side.min_val + r_side.chroma;
      end
      SEC_G_C: begin
        out_data_nxt.green_out = r_side.min_val + r_side.chroma;
        out_data_nxt.blue_out  = r_side.min_val + x_quo;
      end
      SEC_C_B: begin
        out_data_nxt.green_out = r_side.min_val + x_quo;
        out_data_nxt.blue_out  = r_side.min_val + r_side.chroma;
      end
      SEC_B_M: begin
        out_data_nxt.red_out   = r_side.min_val + x_quo;
        out_data_nxt.blue_out  = r_side.min_val + r_side.chroma;
      end
      default: begin
        out_data_nxt.red_out   = r_side.min_val + r_side.chroma;
        out_data_nxt.blue_out  = r_side.min_val + x_quo;
      end
    endcase
  end

  // output register handshake
  assign r_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (r_free) begin
      out_valid_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // input backs up only when every stage is full and the output is held
  a_stall_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // offset comes out of reset at 180 degrees
  a_offset_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (hue_offset_r == OFFSET_RESET))
    else $error("hue offset not at reset value");

  // a register write lands in the offset
  a_offset_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en_w |=> (hue_offset_r == $past(pwdata[OFFSET_W-1:0])))
    else $error("hue offset write lost");
`endif

endmodule

// ----- tb/hue_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hue_checker: scoreboard for the hue rotation pixel block
// Watches the pixel input, pixel output and register port. Every accepted
// input beat is rotated by a local model of the hue arithmetic using the
// offset seen on the register port, and each output beat is compared field
// by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module hue_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  hrp_pkg::pix_in_t               in_data,
  input  logic                           in_stall,
  input  logic                           out_valid,
  input  hrp_pkg::pix_out_t              out_data,
  input  logic                           out_stall,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hrp_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             mismatch_count,
  output int                             pixels_in_flight
);
  import hrp_pkg::*;

  // hue units: 1/64 degree
  localparam int HUE_UNIT   = 1 << HUE_FRAC_DEF;
  localparam int SIXTY      = 60 * HUE_UNIT;
  localparam int FULL_TURN  = 6 * SIXTY;

  typedef struct packed {
    pix_in_t  pixel;
    pix_out_t want;
  } rotated_pixel_t;

  rotated_pixel_t      expected_pixels[$];
  logic [OFFSET_W-1:0] hue_offset;

  initial begin
    mismatch_count   = 0;
    pixels_in_flight = 0;
    hue_offset       = OFFSET_RESET;
  end

  // rotate one pixel by the given offset in degrees
  function automatic pix_out_t rotate_hue(input pix_in_t px, input logic [OFFSET_W-1:0] offset);
    int       r, g, b, mx, mn, c, h, t, d, x, ro, go, bo;
    sector_t  sec;
    pix_out_t res;
    r  = px.red_in;
    g  = px.green_in;
    b  = px.blue_in;
    mx = (r > g) ? r : g;
    mx = (b > mx) ? b : mx;
    mn = (r < g) ? r : g;
    mn = (b < mn) ? b : mn;
    c  = mx - mn;
    // minimum channel picks the base, blue first, then red, then green
    if (c == 0)
      h = 0;
    else if (mn == b)
      h = (SIXTY * (g - r + c)) / c;
    else if (mn == r)
      h = 2 * SIXTY + (SIXTY * (b - g + c)) / c;
    else
      h = 4 * SIXTY + (SIXTY * (r - b + c)) / c;
    h   = (h + int'(offset) * HUE_UNIT) % FULL_TURN;
    sec = sector_t'(h / SIXTY);
    t   = h % (2 * SIXTY);
    d   = (t >= SIXTY) ? (t - SIXTY) : (SIXTY - t);
    x   = (c * (SIXTY - d)) / SIXTY;
    // rebuild from the minimum plus chroma or x
    ro = mn;
    go = mn;
    bo = mn;
    case (sec)
      SEC_R_Y: begin ro += c; go += x; end
      SEC_Y_G: begin ro += x; go += c; end
      SEC_G_C: begin go += c; bo += x; end
      SEC_C_B: begin go += x; bo += c; end
      SEC_B_M: begin ro += x; bo += c; end
      default: begin ro += c; bo += x; end
    endcase
    res.red_out   = ro[PIX_W-1:0];
    res.green_out = go[PIX_W-1:0];
    res.blue_out  = bo[PIX_W-1:0];
    return res;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_channel(input string name, input int got, input int want,
                               input pix_in_t px);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d for pixel r=%0d g=%0d b=%0d",
                                name, got, want, px.red_in, px.green_in, px.blue_in));
  endtask

  // watch all three ports at the rising edge
  always @(posedge clk) begin : watch
    rotated_pixel_t head;
    if (!rst_n) begin
      hue_offset <= OFFSET_RESET;
      expected_pixels.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat r=%0d g=%0d b=%0d",
                                    out_data.red_out, out_data.green_out, out_data.blue_out));
        end else begin
          head = expected_pixels.pop_front();
          check_channel("red",   out_data.red_out,   head.want.red_out,   head.pixel);
          check_channel("green", out_data.green_out, head.want.green_out, head.pixel);
          check_channel("blue",  out_data.blue_out,  head.want.blue_out,  head.pixel);
        end
      end
      // input beat gets its prediction
      if (in_valid && !in_stall) begin
        head.pixel = in_data;
        head.want  = rotate_hue(in_data, hue_offset);
        expected_pixels.push_back(head);
      end
      // register write, other indexes are ignored
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_HUE_OFFSET)
        hue_offset <= pwdata[OFFSET_W-1:0];
    end
    pixels_in_flight <= expected_pixels.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the hue rotation pixel block
// Sends directed corner pixels at the reset offset, then phases of random
// pixels under several hue offsets, with random gaps on the input and random
// stalls on the output. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import hrp_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int PHASES        = 8;
  localparam int PHASE_PIXELS  = 175;
  localparam int DRAIN_CYCLES  = 40;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam logic [CFG_ADDR_W-3:0] REG_SPARE = 1'b1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  pix_in_t               in_data;
  logic                  in_stall;
  logic                  out_valid;
  pix_out_t              out_data;
  logic                  out_stall;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    pixels_in_flight;
  bit                    quiet;

  hue_rotation_pixel u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  hue_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_data          (in_data),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_data         (out_data),
    .out_stall        (out_stall),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // idle cycles before a beat, none in quiet phases
  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // random pixel, biased toward gray, ties and extremes
  function automatic pix_in_t random_pixel();
    pix_in_t          px;
    logic [PIX_W-1:0] v;
    px.red_in   = PIX_W'($urandom_range(0, PIX_MAX));
    px.green_in = PIX_W'($urandom_range(0, PIX_MAX));
    px.blue_in  = PIX_W'($urandom_range(0, PIX_MAX));
    v           = PIX_W'($urandom_range(0, PIX_MAX));
    case ($urandom_range(0, 9))
      0: begin
        px.red_in   = v;
        px.green_in = v;
        px.blue_in  = v;
      end
      1, 2: begin
        case ($urandom_range(0, 2))
          0:       px.red_in   = px.green_in;
          1:       px.green_in = px.blue_in;
          default: px.blue_in  = px.red_in;
        endcase
      end
      3: begin
        px.red_in   = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
        px.green_in = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
        px.blue_in  = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
      end
      default: ;
    endcase
    return px;
  endfunction

  // input beat, held until accepted
  task automatic send_pixel(input pix_in_t px);
    int n;
    n = draw_wait();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    pix_in_t px;
    px.red_in   = PIX_W'(r);
    px.green_in = PIX_W'(g);
    px.blue_in  = PIX_W'(b);
    send_pixel(px);
  endtask

  // apb write: setup then access
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait for every result
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pixels_in_flight != 0);
  endtask

  // output side: random stall before each result beat
  initial begin : result_sink
    int n;
    wait (rst_n === 1'b1);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // main stimulus
  initial begin : stimulus
    logic [OFFSET_W-1:0]   offset;
    logic [CFG_DATA_W-1:0] data;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // corner pixels at the reset offset
    send_rgb(0, 0, 0);       send_rgb(255, 255, 255); send_rgb(128, 128, 128);
    send_rgb(255, 0, 0);     send_rgb(0, 255, 0);     send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);   send_rgb(0, 255, 255);   send_rgb(255, 0, 255);
    send_rgb(1, 0, 0);       send_rgb(0, 1, 0);       send_rgb(0, 0, 1);
    send_rgb(255, 254, 0);   send_rgb(0, 254, 255);   send_rgb(254, 0, 255);
    send_rgb(10, 20, 30);    send_rgb(30, 20, 10);    send_rgb(200, 100, 50);
    send_rgb(1, 2, 3);       send_rgb(255, 1, 0);     send_rgb(0, 1, 255);
    wait_idle();

    // write to an unused index must leave the offset alone
    apb_write({REG_SPARE, 2'b00}, $urandom);

    for (int phase = 0; phase < PHASES; phase++) begin
      // offsets cover both ends and the out-of-range values
      case (phase)
        0:       offset = '0;
        1:       offset = OFFSET_W'(359);
        2:       offset = OFFSET_W'(OFFSET_MAX);
        3:       offset = OFFSET_W'(360);
        4:       offset = OFFSET_W'(1);
        5:       offset = OFFSET_W'($urandom_range(0, OFFSET_MAX));
        default: offset = OFFSET_W'($urandom_range(0, 359));
      endcase
      data                = $urandom;
      data[OFFSET_W-1:0]  = offset;
      quiet               = (phase == 2 || phase == 5);
      wait_idle();
      apb_write({REG_HUE_OFFSET, 2'b00}, data);
      if (phase == 6)
        apb_write({REG_SPARE, 2'b00}, $urandom);
      for (int i = 0; i < PHASE_PIXELS; i++)
        send_pixel(random_pixel());
    end

    // drain, then verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
